[sv/bpc_pkg.sv]
// shared types, constants and configuration layout of the button press classifier
package bpc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int THR_WIDTH   = 16;
	localparam int CMP_WIDTH   = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [THR_WIDTH-1:0]   thr_t;
	typedef logic [CMP_WIDTH-1:0]   cmp_t;

	localparam cnt_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [2:0] {
		EV_SHORT   = 3'd0,
		EV_LONG    = 3'd1,
		EV_DOUBLE  = 3'd2,
		EV_IGNORED = 3'd3,
		EV_GLITCH  = 3'd4
	} ev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_LEVEL = 2'd0,
		REG_SHORT_TICKS  = 2'd1,
		REG_LONG_TICKS   = 2'd2,
		REG_WINDOW_TICKS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic active_level;
		thr_t short_ticks;
		thr_t long_ticks;
		thr_t double_window_ticks;
	} cfg_t;

	localparam logic RST_ACTIVE_LEVEL = 1'b0;
	localparam thr_t RST_SHORT_TICKS  = 16'd5;
	localparam thr_t RST_LONG_TICKS   = 16'd500;
	localparam thr_t RST_WINDOW_TICKS = 16'd50;

endpackage

[sv/bpc_cfg.sv]
// configuration register file of the button press classifier
module bpc_cfg
	import bpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level        <= RST_ACTIVE_LEVEL;
			cfg_q.short_ticks         <= RST_SHORT_TICKS;
			cfg_q.long_ticks          <= RST_LONG_TICKS;
			cfg_q.double_window_ticks <= RST_WINDOW_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ACTIVE_LEVEL: cfg_q.active_level        <= cfg_data[0];
				REG_SHORT_TICKS:  cfg_q.short_ticks         <= thr_t'(cfg_data);
				REG_LONG_TICKS:   cfg_q.long_ticks          <= thr_t'(cfg_data);
				REG_WINDOW_TICKS: cfg_q.double_window_ticks <= thr_t'(cfg_data);
				default: ;
			endcase
		end
	end

endmodule

[sv/bpc_core.sv]
// input register, press counters, classification and result register
module bpc_core
	import bpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_code
);

	logic valid_s1;
	logic level_s1;
	cnt_t held_q;
	cnt_t gap_q;
	logic out_valid_q;
	ev_t  event_q;

	logic advance;
	logic pressed;
	logic fire;
	ev_t  ev;
	cnt_t held_nxt;
	cnt_t gap_mid;
	cnt_t gap_nxt;
	cnt_t win_sat;
	cmp_t held_c, gap_c, short_c, long_c, win_c, half_c;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		held_c  = cmp_t'(held_q);
		gap_c   = cmp_t'(gap_q);
		short_c = cmp_t'(cfg.short_ticks);
		long_c  = cmp_t'(cfg.long_ticks);
		win_c   = cmp_t'(cfg.double_window_ticks);
		half_c  = cmp_t'(cfg.short_ticks >> 1);
		win_sat = (win_c > cmp_t'(COUNT_MAX)) ? COUNT_MAX
			: cnt_t'(cfg.double_window_ticks);
		pressed  = (level_s1 == cfg.active_level);
		fire     = 1'b0;
		ev       = EV_SHORT;
		gap_mid  = gap_q;
		held_nxt = held_q;
		if (pressed) begin
			if (held_c == long_c && held_q != COUNT_MAX) begin
				fire = 1'b1;
				ev   = EV_LONG;
			end
			held_nxt = (held_q == COUNT_MAX) ? held_q : held_q + 1'b1;
		end else begin
			if (held_c >= long_c) begin
				gap_mid = '0;
			end else if (held_c >= short_c) begin
				fire = 1'b1;
				if (gap_c < win_c) begin
					ev      = (gap_c > half_c) ? EV_DOUBLE : EV_IGNORED;
					gap_mid = win_sat;
				end else begin
					ev      = EV_SHORT;
					gap_mid = '0;
				end
			end else if (held_q != '0) begin
				fire = 1'b1;
				ev   = EV_GLITCH;
			end
			held_nxt = '0;
		end
		gap_nxt = (gap_mid == COUNT_MAX) ? gap_mid : gap_mid + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			gap_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && fire;
			if (valid_s1) begin
				held_q <= held_nxt;
				gap_q  <= gap_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && fire) begin
			event_q <= ev;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

endmodule

[sv/button_press_classifier_top.sv]
// top level of the button press classifier
//
// one item on the input channel is one sampled button level for one tick.
// the block counts held ticks and ticks since release, both saturating, and
// emits at most one event per item on the output channel: short, long,
// double, ignored double or too-short glitch.
// an accepted item is registered in the input register, classified against the
// counters and written to the result register, from which its event shows on
// the output; a receiver stall can hold it in the input register. items that
// cause no event update the counters and leave the output empty.
// throughput is one item per cycle while the receiver takes results, set by
// the single counter update per tick.
// when the receiver stalls a pending event holds; one more item can sit in
// the input register, after which in_ready drops.
// reset clears the counters and pipeline and loads the default thresholds.
// the configuration channel is always ready; it must be written while idle, which the block itself does not enforce.
module button_press_classifier_top
	import bpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_code
);

	cfg_t cfg;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.level      (level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code)
	);

endmodule

[sv/bpc_checker.sv]
// port-level checks of the button press classifier and their binding
module bpc_checker
	import bpc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_ready,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_code
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pending item dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(event_code))
		else $error("pending item changed");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= 3'd4)
		else $error("event code out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind button_press_classifier_top bpc_checker u_bpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_ready  (cfg_ready),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_code (event_code)
);
